FILE: rtl/core/tgq_pkg.sv
package tgq_pkg;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [2:0] MODE_WHILE_DOWN = 3'd0;
    localparam logic [2:0] MODE_ON_TOUCH   = 3'd1;
    localparam logic [2:0] MODE_ON_RELEASE = 3'd2;
    localparam logic [2:0] MODE_LONG_PRESS = 3'd3;
    localparam logic [2:0] MODE_MULTITAP   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_GESTURE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_WINDOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_MSG_CNT  = 3'd4;

    localparam logic [7:0] TAP_COUNT_MAX = 8'd255;

    typedef struct packed {
        logic [2:0]  gesture_mode;
        logic [15:0] debounce_ms;
        logic [15:0] hold_ms;
        logic [15:0] tap_window_ms;
        logic [7:0]  tap_message_count;
    } cfg_t;

    typedef struct packed {
        logic        action;
        logic        touch_level;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic       poll_true;
        logic       message_fired;
        logic [7:0] tap_index;
    } result_t;

endpackage

FILE: rtl/core/tgq_cfg_regs.sv
module tgq_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tgq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tgq_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tgq_pkg::cfg_t                    cfg
);
    import tgq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_GESTURE_MODE: cfg_next.gesture_mode      = cfg_data[2:0];
                REG_DEBOUNCE:     cfg_next.debounce_ms       = cfg_data[15:0];
                REG_HOLD:         cfg_next.hold_ms           = cfg_data[15:0];
                REG_TAP_WINDOW:   cfg_next.tap_window_ms     = cfg_data[15:0];
                REG_TAP_MSG_CNT:  cfg_next.tap_message_count = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gesture_mode      <= MODE_ON_TOUCH;
            cfg_reg.debounce_ms       <= 16'd50;
            cfg_reg.hold_ms           <= 16'd1000;
            cfg_reg.tap_window_ms     <= 16'd300;
            cfg_reg.tap_message_count <= 8'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/tgq_core.sv
module tgq_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  tgq_pkg::item_t    item,
    input  tgq_pkg::cfg_t     cfg,
    output tgq_pkg::result_t  result
);
    import tgq_pkg::*;

    logic        allowed_reg, allowed_next;
    logic        last_reg, last_next;
    logic [31:0] event_reg, event_next;
    logic        held_reg, held_next;
    logic [7:0]  tap_reg, tap_next;

    logic        allowed_g;
    logic        last_g;
    logic [31:0] elapsed;
    logic        held_v;
    logic        want;
    logic [7:0]  tap_m1;

    always_comb begin
        if (allowed_reg) begin
            allowed_g = 1'b1;
            last_g    = last_reg;
        end else begin
            allowed_g = !item.touch_level && !last_reg;
            last_g    = item.touch_level;
        end
        elapsed = item.now_ms - event_reg;
        want    = (cfg.gesture_mode == MODE_ON_TOUCH);
        tap_m1  = tap_reg - 8'd1;
        held_v  = held_reg;

        allowed_next = allowed_reg;
        last_next    = last_reg;
        event_next   = event_reg;
        held_next    = held_reg;
        tap_next     = tap_reg;
        result       = '0;

        if (item.action) begin
            allowed_next = 1'b0;
        end else begin
            case (cfg.gesture_mode)
                MODE_WHILE_DOWN: begin
                    allowed_next = allowed_g;
                    last_next    = last_g;
                    if (allowed_g) begin
                        last_next        = item.touch_level;
                        result.poll_true = item.touch_level;
                    end
                end
                MODE_ON_TOUCH, MODE_ON_RELEASE: begin
                    allowed_next = allowed_g;
                    last_next    = last_g;
                    if (!allowed_g) begin
                        event_next = item.now_ms;
                    end else if (last_g != item.touch_level &&
                                 elapsed > {16'd0, cfg.debounce_ms}) begin
                        if (item.touch_level == want) begin
                            result.poll_true     = 1'b1;
                            result.message_fired = 1'b1;
                            event_next           = item.now_ms;
                        end
                        last_next = item.touch_level;
                    end
                end
                MODE_LONG_PRESS: begin
                    allowed_next = allowed_g;
                    last_next    = last_g;
                    if (!allowed_g) begin
                        held_next = 1'b0;
                    end else if (last_g != item.touch_level) begin
                        held_next = item.touch_level;
                        last_next = item.touch_level;
                        if (item.touch_level) begin
                            event_next = item.now_ms;
                        end
                    end else if (held_v && elapsed > {16'd0, cfg.hold_ms}) begin
                        held_next            = 1'b0;
                        result.poll_true     = 1'b1;
                        result.message_fired = 1'b1;
                    end
                end
                MODE_MULTITAP: begin
                    if (!allowed_reg) begin
                        last_next    = 1'b0;
                        event_next   = item.now_ms;
                        tap_next     = 8'd0;
                        allowed_next = 1'b1;
                    end else if (tap_reg != 8'd0 &&
                                 elapsed > {16'd0, cfg.tap_window_ms}) begin
                        if (tap_m1 < cfg.tap_message_count) begin
                            result.poll_true     = 1'b1;
                            result.message_fired = 1'b1;
                            result.tap_index     = tap_m1;
                        end
                        allowed_next = 1'b0;
                    end else if (item.touch_level != last_reg) begin
                        last_next        = item.touch_level;
                        result.poll_true = 1'b1;
                        if (!item.touch_level) begin
                            event_next = item.now_ms;
                            if (tap_reg != TAP_COUNT_MAX) begin
                                tap_next = tap_reg + 8'd1;
                            end
                        end
                    end
                end
                default: begin
                    result = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allowed_reg <= 1'b1;
            last_reg    <= 1'b0;
            event_reg   <= 32'd0;
            held_reg    <= 1'b0;
            tap_reg     <= 8'd0;
        end else if (step) begin
            allowed_reg <= allowed_next;
            last_reg    <= last_next;
            event_reg   <= event_next;
            held_reg    <= held_next;
            tap_reg     <= tap_next;
        end
    end

endmodule

FILE: rtl/core/touch_gesture_qualifier.sv
// Touch gesture qualifier.
// Input channel s_*: one word per pad poll or re-arm request. s_tuser is the
// action flag (1 re-arm, 0 poll); s_tdata carries the pad level and the
// millisecond timestamp. Every accepted word yields exactly one result word
// on m_*: poll return value, message-fired flag and multitap index.
// Configuration channel cfg_*: register index and data, always ready; write
// it only while no word is in flight.
// A word accepted on s_* is held in the input register, then its result in
// the result register, which drives m_*.
// One word per cycle while m_tready is high; the gesture state update is a
// single pass of compares and one 32-bit subtract between the two registers.
// Reset (aresetn low, synchronous) empties both registers, restores the
// register defaults and re-opens the input gate.
// When m_tready is low the result word holds; the input register still takes
// one more word, after which s_tready drops until the result is taken.
module touch_gesture_qualifier (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic                             s_tuser,   // [0] action
    input  logic [tgq_pkg::S_TDATA_W-1:0]    s_tdata,   // [0] touch_level, [32:1] now_ms
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tgq_pkg::M_TDATA_W-1:0]    m_tdata,   // [0] poll_true, [1] message_fired,
                                                        // [9:2] tap_index
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tgq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tgq_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tgq_pkg::*;

    logic    in_vld_reg;
    item_t   in_item_reg;
    logic    out_vld_reg;
    result_t out_res_reg;
    logic    advance;
    cfg_t    cfg;
    result_t res;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    tgq_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tgq_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.action      <= s_tuser;
            in_item_reg.touch_level <= s_tdata[0];
            in_item_reg.now_ms      <= s_tdata[32:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_res_reg.tap_index, out_res_reg.message_fired,
                       out_res_reg.poll_true};

endmodule

FILE: rtl/core/tgq_checker.sv
module tgq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tgq_pkg::M_TDATA_W-1:0] m_tdata
);
    import tgq_pkg::*;

    // hold result while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // drop output on reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("message fired without poll true");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:2] != 8'd0 |-> m_tdata[1])
        else $error("tap index set without a fired message");

endmodule

bind touch_gesture_qualifier tgq_checker u_tgq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: test/gesture_checker.sv
module gesture_checker
    import tgq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  s_tuser,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding
);

    cfg_t        regs;
    logic        armed;
    logic        prev_level;
    logic [31:0] mark_ms;
    logic        held;
    logic [7:0]  taps;
    result_t     expected_q[$];
    int          errors;

    assign fail_count = errors;

    function automatic bit gate_reopens(input logic lvl);
        if (!armed) begin
            if (lvl)
                armed = 1'b0;
            else if (prev_level == lvl)
                armed = 1'b1;
            prev_level = lvl;
        end
        return armed;
    endfunction

    function automatic result_t predict_gesture(input logic act, input logic lvl,
                                                input logic [31:0] stamp);
        result_t     r;
        logic [31:0] since;
        logic [7:0]  last_tap;
        r = '0;
        since = stamp - mark_ms;
        if (act) begin
            armed = 1'b0;
        end else begin
            case (regs.gesture_mode)
                MODE_WHILE_DOWN: begin
                    if (gate_reopens(lvl)) begin
                        prev_level = lvl;
                        r.poll_true = lvl;
                    end
                end
                MODE_ON_TOUCH, MODE_ON_RELEASE: begin
                    if (!gate_reopens(lvl)) begin
                        mark_ms = stamp;
                    end else if (prev_level != lvl && since > 32'(regs.debounce_ms)) begin
                        if (lvl == (regs.gesture_mode == MODE_ON_TOUCH)) begin
                            r.poll_true = 1'b1;
                            r.message_fired = 1'b1;
                            mark_ms = stamp;
                        end
                        prev_level = lvl;
                    end
                end
                MODE_LONG_PRESS: begin
                    if (!gate_reopens(lvl)) begin
                        held = 1'b0;
                    end else begin
                        if (prev_level != lvl) begin
                            held = lvl;
                            if (lvl)
                                mark_ms = stamp;
                            prev_level = lvl;
                        end
                        since = stamp - mark_ms;
                        if (held && since > 32'(regs.hold_ms)) begin
                            held = 1'b0;
                            r.poll_true = 1'b1;
                            r.message_fired = 1'b1;
                        end
                    end
                end
                MODE_MULTITAP: begin
                    if (!armed) begin
                        prev_level = 1'b0;
                        mark_ms = stamp;
                        taps = '0;
                        armed = 1'b1;
                    end else if (taps != 0 && since > 32'(regs.tap_window_ms)) begin
                        last_tap = taps - 8'd1;
                        if (last_tap < regs.tap_message_count) begin
                            r.poll_true = 1'b1;
                            r.message_fired = 1'b1;
                            r.tap_index = last_tap;
                        end
                        armed = 1'b0;
                    end else if (lvl != prev_level) begin
                        prev_level = lvl;
                        if (!lvl) begin
                            mark_ms = stamp;
                            if (taps != TAP_COUNT_MAX)
                                taps = taps + 8'd1;
                        end
                        r.poll_true = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            regs.gesture_mode      = MODE_ON_TOUCH;
            regs.debounce_ms       = 16'd50;
            regs.hold_ms           = 16'd1000;
            regs.tap_window_ms     = 16'd300;
            regs.tap_message_count = 8'd0;
            armed       = 1'b1;
            prev_level  = 1'b0;
            mark_ms     = '0;
            held        = 1'b0;
            taps        = '0;
            expected_q.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GESTURE_MODE: regs.gesture_mode      = cfg_data[2:0];
                    REG_DEBOUNCE:     regs.debounce_ms       = cfg_data;
                    REG_HOLD:         regs.hold_ms           = cfg_data;
                    REG_TAP_WINDOW:   regs.tap_window_ms     = cfg_data;
                    REG_TAP_MSG_CNT:  regs.tap_message_count = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_gesture(s_tuser, s_tdata[0], s_tdata[32:1]));
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[1], m_tdata[9:2]};
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
                end else begin
                    want = expected_q.pop_front();
                    check_field("poll_true", want.poll_true, got.poll_true);
                    check_field("message_fired", want.message_fired, got.message_fired);
                    check_field("tap_index", want.tap_index, got.tap_index);
                end
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

FILE: test/testbench.sv
module testbench;
    import tgq_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_WORDS   = 520;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic                  s_tuser = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;      // [0] touch_level, [32:1] now_ms
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;           // [0] poll_true, [1] message_fired, [9:2] tap_index
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int          fail_count;
    int          outstanding;
    int          idle_pct = 12;
    int          stall_pct = 12;
    int          quiet_cycles = 0;
    logic [31:0] clock_ms = '0;
    logic        pad = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    touch_gesture_qualifier u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    gesture_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_word(input logic act, input logic lvl, input logic [31:0] stamp);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct)
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W-33){1'b0}}, stamp, lvl};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic poll(input logic lvl, input logic [31:0] dt);
        clock_ms = clock_ms + dt;
        pad = lvl;
        push_word(1'b0, lvl, clock_ms);
    endtask

    task automatic rearm();
        push_word(1'b1, 1'($urandom), $urandom);
    endtask

    // hold off until every word in flight has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic program_regs(input logic [15:0] mode_w, input logic [15:0] deb,
                                input logic [15:0] hold, input logic [15:0] win,
                                input logic [15:0] msg_w, input bit junk);
        logic [CFG_IDX_W-1:0]  idx_list[6];
        logic [CFG_DATA_W-1:0] val_list[6];
        idx_list = '{REG_GESTURE_MODE, REG_DEBOUNCE, REG_HOLD, REG_TAP_WINDOW,
                     REG_TAP_MSG_CNT, REG_UNUSED};
        val_list = '{mode_w, deb, hold, win, msg_w, 16'($urandom)};
        for (int i = 0; i < (junk ? 6 : 5); i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= val_list[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_ms();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'd0;
        else if (r < 20)
            return 16'hFFFF;
        else if (r < 30)
            return 16'($urandom);
        return 16'($urandom_range(120, 1));
    endfunction

    initial begin
        int          random_words;
        int          len;
        int          r;
        logic [2:0]  mode;
        logic [15:0] deb;
        logic [15:0] hold;
        logic [15:0] win;
        logic [7:0]  msg;
        logic [31:0] thr;
        logic [31:0] dt;
        logic        lvl;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // on-touch at reset defaults, through a re-arm and a timestamp wrap
        poll(1'b1, 51);
        poll(1'b0, 10);
        poll(1'b0, 50);
        rearm();
        poll(1'b1, 5);
        poll(1'b0, 5);
        poll(1'b0, 5);
        poll(1'b1, 51);
        clock_ms = 32'hFFFF_FFE0;
        poll(1'b0, 0);
        poll(1'b1, 32'h40);
        drain();
        program_regs(16'hFFF8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF00, 1'b1);
        poll(1'b1, 1);
        poll(1'b0, 1);
        rearm();
        poll(1'b0, 1);
        poll(1'b1, 1);
        drain();
        program_regs(16'(MODE_ON_RELEASE), 16'd0, 16'd0, 16'd0, 16'd255, 1'b0);
        poll(1'b0, 0);
        poll(1'b1, 0);
        poll(1'b1, 1);
        drain();
        program_regs(16'(MODE_LONG_PRESS), 16'd0, 16'd0, 16'd0, 16'd255, 1'b0);
        poll(1'b1, 1);
        poll(1'b0, 1);
        poll(1'b1, 0);
        poll(1'b1, 1);
        drain();
        program_regs(16'(MODE_MULTITAP), 16'd0, 16'd0, 16'd0, 16'd255, 1'b0);
        poll(1'b0, 1);
        poll(1'b1, 0);
        poll(1'b0, 0);
        poll(1'b0, 1);
        poll(1'b0, 1);
        drain();
        program_regs(16'd5, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        poll(1'b1, 1);
        rearm();
        drain();
        program_regs(16'd7, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        poll(1'b0, 1);

        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            drain();
            r = $urandom_range(99);
            mode = (r < 95) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
            deb  = pick_ms();
            hold = pick_ms();
            win  = pick_ms();
            r = $urandom_range(99);
            msg = (r < 50) ? 8'($urandom_range(4)) : (r < 60) ? 8'hFF : 8'($urandom);
            program_regs({13'($urandom), mode}, deb, hold, win, {8'($urandom), msg},
                         $urandom_range(9) == 0);
            case (mode)
                MODE_ON_TOUCH, MODE_ON_RELEASE: thr = deb;
                MODE_LONG_PRESS:                thr = hold;
                MODE_MULTITAP:                  thr = win;
                default:                        thr = 32'd20;
            endcase
            len = $urandom_range(50, 10);
            for (int i = 0; i < len; i++) begin
                if (random_words >= 200 && random_words < 330) begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end else begin
                    idle_pct  = 12;
                    stall_pct = 12;
                end
                r = $urandom_range(99);
                if (r < 5) begin
                    rearm();
                end else begin
                    lvl = (r < 70) ? !pad : 1'($urandom);
                    r = $urandom_range(99);
                    if (r < 45)
                        dt = $urandom_range(thr, 0);
                    else if (r < 90)
                        dt = thr + $urandom_range(40, 1);
                    else if (r < 95)
                        dt = $urandom;
                    else
                        dt = 0;
                    poll(lvl, dt);
                end
                if (mode <= MODE_MULTITAP)
                    random_words++;
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
